// ===== sv/kvs_pkg.sv =====
// Shared types and constants for the keyframe vector sampler.
package kvs_pkg;

    // Operation codes of an input request
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Result case codes
    localparam logic [1:0] CASE_FIRST  = 2'd0;
    localparam logic [1:0] CASE_INTERP = 2'd1;
    localparam logic [1:0] CASE_LAST   = 2'd2;

    // Register map: register index taken from paddr[2]
    localparam int          PADDR_W         = 3;
    localparam logic        REG_KEY_COUNT   = 1'b0;
    localparam logic [6:0]  KEY_COUNT_RESET = 7'd1;

    // Fraction division: 1 integer step plus 16 fraction steps
    localparam logic [4:0]  DIV_LAST_STEP = 5'd16;
    localparam logic [1:0]  COMP_LAST     = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [5:0]         key_index;
        logic [31:0]        key_time;
        logic [31:0]        sample_time;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [5:0]         segment;
        logic [1:0]         case_taken;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ0,
        ST_CHECK0,
        ST_SCAN,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_ACCUM,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic write_entry;  // store the input request in the key table
        logic scan_start;   // latch query time, restart the read index
        logic idx_inc;      // advance the read index
        logic take_first;   // result is entry 0
        logic keep_prev;    // current entry becomes the earlier key
        logic latch_span;   // bracketing pair found, set up the division
        logic hold_last;    // result is the last entry
        logic div_step;     // one quotient bit
        logic mul;          // one component product
        logic accum;        // add product to the earlier value
        logic out_load;     // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic one_key;
        logic first_hit;
        logic bracket;
        logic at_last;
        logic div_done;
        logic comp_last;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/kvs_ctrl.sv =====
// Sequencing state machine of the keyframe vector sampler.
module kvs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_operation,
    input  kvs_pkg::t_sts i_sts,
    output kvs_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    kvs_pkg::t_state r_state;
    kvs_pkg::t_state n_state;
    logic            accept;

    assign accept     = i_in_valid && (r_state == kvs_pkg::ST_IDLE);
    assign o_in_stall = (r_state != kvs_pkg::ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kvs_pkg::ST_IDLE: begin
                if (accept && i_operation == kvs_pkg::OP_SAMPLE) begin
                    n_state = kvs_pkg::ST_READ0;
                end
            end
            kvs_pkg::ST_READ0: begin
                n_state = kvs_pkg::ST_CHECK0;
            end
            kvs_pkg::ST_CHECK0: begin
                if (i_sts.one_key || i_sts.first_hit) begin
                    n_state = kvs_pkg::ST_DONE;
                end else begin
                    n_state = kvs_pkg::ST_SCAN;
                end
            end
            kvs_pkg::ST_SCAN: begin
                if (i_sts.bracket) begin
                    n_state = kvs_pkg::ST_DIVIDE;
                end else if (i_sts.at_last) begin
                    n_state = kvs_pkg::ST_DONE;
                end
            end
            kvs_pkg::ST_DIVIDE: begin
                if (i_sts.div_done) begin
                    n_state = kvs_pkg::ST_MULTIPLY;
                end
            end
            kvs_pkg::ST_MULTIPLY: begin
                n_state = kvs_pkg::ST_ACCUM;
            end
            kvs_pkg::ST_ACCUM: begin
                if (i_sts.comp_last) begin
                    n_state = kvs_pkg::ST_DONE;
                end else begin
                    n_state = kvs_pkg::ST_MULTIPLY;
                end
            end
            kvs_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = kvs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kvs_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            kvs_pkg::ST_IDLE: begin
                o_cmd.write_entry = accept && (i_operation == kvs_pkg::OP_WRITE);
                o_cmd.scan_start  = accept && (i_operation == kvs_pkg::OP_SAMPLE);
            end
            kvs_pkg::ST_READ0: begin
                o_cmd.idx_inc = 1'b1;
            end
            kvs_pkg::ST_CHECK0: begin
                if (i_sts.one_key || i_sts.first_hit) begin
                    o_cmd.take_first = 1'b1;
                end else begin
                    o_cmd.keep_prev = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                end
            end
            kvs_pkg::ST_SCAN: begin
                if (i_sts.bracket) begin
                    o_cmd.latch_span = 1'b1;
                end else if (i_sts.at_last) begin
                    o_cmd.hold_last = 1'b1;
                end else begin
                    o_cmd.keep_prev = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                end
            end
            kvs_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            kvs_pkg::ST_MULTIPLY: begin
                o_cmd.mul = 1'b1;
            end
            kvs_pkg::ST_ACCUM: begin
                o_cmd.accum = 1'b1;
            end
            kvs_pkg::ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/kvs_datapath.sv =====
// Key table, search compare, fraction divider, interpolator and output register.
module kvs_datapath #(
    parameter int KEY_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kvs_pkg::t_in_req  i_in_req,
    input  logic [6:0]        i_key_count,
    input  kvs_pkg::t_cmd     i_cmd,
    output kvs_pkg::t_sts     o_sts,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output kvs_pkg::t_out_req o_out_req
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int NW = (AW + 1 > 7) ? AW + 1 : 7;
    localparam int EW = 128;  // time plus three components

    // Key table: {time, x, y, z}
    logic [EW-1:0] r_mem [KEY_DEPTH];
    logic [EW-1:0] r_rd;

    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_rd_idx;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] last_idx;
    logic [31:0]   wr_idx32;
    logic          wr_ok;

    logic [31:0]        r_time;
    logic [31:0]        r_prev_t;
    logic signed [31:0] r_prev_v [3];
    logic [31:0]        r_d;
    logic [31:0]        r_span;
    logic signed [32:0] r_diff [3];

    logic [31:0] rd_t;
    logic signed [31:0] rd_v [3];

    logic [31:0] r_rem;
    logic [16:0] r_q;
    logic [4:0]  r_step;
    logic [1:0]  r_comp;
    logic signed [50:0] r_prod;

    logic signed [31:0] r_res [3];
    logic [AW-1:0]      r_seg;
    logic [1:0]         r_case;
    logic               r_out_valid;
    kvs_pkg::t_out_req  r_out;

    logic [NW-1:0] kc_ext;
    logic [NW-1:0] n_keys;
    logic [NW-1:0] last_full;

    logic [32:0] div_sh;
    logic        div_ge;
    logic [32:0] div_sub;
    logic [16:0] frac;
    logic signed [17:0] frac_s;
    logic signed [32:0] diff_sel;
    logic signed [31:0] v0_sel;
    logic signed [50:0] mul_p;
    logic [31:0]        seg32;

    // Last valid key: count of zero reads as one, count saturates at the depth
    always_comb begin
        kc_ext = NW'(i_key_count);
        n_keys = (kc_ext == '0) ? NW'(1) : kc_ext;
        if (n_keys > NW'(KEY_DEPTH)) begin
            last_full = NW'(KEY_DEPTH - 1);
        end else begin
            last_full = n_keys - NW'(1);
        end
        last_idx = last_full[AW-1:0];
    end

    // Write address; indexes beyond the table are dropped
    assign wr_idx32 = 32'(i_in_req.key_index);
    assign wr_ok    = wr_idx32 < 32'(KEY_DEPTH);
    assign rd_addr  = (r_idx > AW'(KEY_DEPTH - 1)) ? AW'(KEY_DEPTH - 1) : r_idx;

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry && wr_ok) begin
            r_mem[wr_idx32[AW-1:0]] <= {i_in_req.key_time, i_in_req.value_x,
                                        i_in_req.value_y, i_in_req.value_z};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign rd_t    = r_rd[127:96];
    assign rd_v[0] = r_rd[95:64];
    assign rd_v[1] = r_rd[63:32];
    assign rd_v[2] = r_rd[31:0];

    // Search status
    assign o_sts.one_key   = (last_idx == '0);
    assign o_sts.first_hit = (r_time <= rd_t);
    assign o_sts.bracket   = (r_prev_t <= r_time) && (r_time <= rd_t);
    assign o_sts.at_last   = (r_rd_idx == last_idx);
    assign o_sts.div_done  = (r_step == kvs_pkg::DIV_LAST_STEP);
    assign o_sts.comp_last = (r_comp == kvs_pkg::COMP_LAST);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // Read index
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        r_rd_idx <= rd_addr;
    end

    // Query time and earlier key
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_time <= i_in_req.sample_time;
        end
        if (i_cmd.keep_prev) begin
            r_prev_t <= rd_t;
            for (int c = 0; c < 3; c++) begin
                r_prev_v[c] <= rd_v[c];
            end
        end
    end

    // Restoring divider: integer bit first, then 16 fraction bits
    assign div_sh  = (r_step == '0) ? {1'b0, r_d} : {r_rem, 1'b0};
    assign div_ge  = (div_sh >= {1'b0, r_span});
    assign div_sub = div_sh - {1'b0, r_span};
    // A zero-length span gives a zero fraction
    assign frac    = (r_span == '0) ? 17'd0 : r_q;
    assign frac_s  = $signed({1'b0, frac});

    // Component selection for the shared multiplier
    always_comb begin
        case (r_comp)
            2'd0: begin
                diff_sel = r_diff[0];
                v0_sel   = r_prev_v[0];
            end
            2'd1: begin
                diff_sel = r_diff[1];
                v0_sel   = r_prev_v[1];
            end
            default: begin
                diff_sel = r_diff[2];
                v0_sel   = r_prev_v[2];
            end
        endcase
    end

    assign mul_p = diff_sel * frac_s;

    // Span setup, division, interpolation and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_comp <= '0;
        end else begin
            if (i_cmd.latch_span) begin
                r_step <= '0;
                r_comp <= '0;
            end else begin
                if (i_cmd.div_step) begin
                    r_step <= r_step + 5'd1;
                end
                if (i_cmd.accum) begin
                    r_comp <= r_comp + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_span) begin
            r_d    <= r_time - r_prev_t;
            r_span <= rd_t - r_prev_t;
            for (int c = 0; c < 3; c++) begin
                r_diff[c] <= {rd_v[c][31], rd_v[c]} - {r_prev_v[c][31], r_prev_v[c]};
            end
            r_seg  <= r_rd_idx - AW'(1);
            r_case <= kvs_pkg::CASE_INTERP;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_sub[31:0] : div_sh[31:0];
            r_q   <= {r_q[15:0], div_ge};
        end
        if (i_cmd.mul) begin
            r_prod <= mul_p;
        end
        if (i_cmd.accum) begin
            case (r_comp)
                2'd0:    r_res[0] <= v0_sel + r_prod[47:16];
                2'd1:    r_res[1] <= v0_sel + r_prod[47:16];
                default: r_res[2] <= v0_sel + r_prod[47:16];
            endcase
        end
        if (i_cmd.take_first) begin
            for (int c = 0; c < 3; c++) begin
                r_res[c] <= rd_v[c];
            end
            r_seg  <= '0;
            r_case <= kvs_pkg::CASE_FIRST;
        end
        if (i_cmd.hold_last) begin
            for (int c = 0; c < 3; c++) begin
                r_res[c] <= rd_v[c];
            end
            r_seg  <= r_rd_idx;
            r_case <= kvs_pkg::CASE_LAST;
        end
    end

    // Output register
    assign seg32 = 32'(r_seg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_x      <= r_res[0];
            r_out.out_y      <= r_res[1];
            r_out.out_z      <= r_res[2];
            r_out.segment    <= seg32[5:0];
            r_out.case_taken <= r_case;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ===== sv/keyframe_vector_sampler.sv =====
// Top level of the keyframe vector sampler: register port and block wiring.
//
// A write request stores one keyframe (Q16.16 time and x/y/z vector) in the
// key table and gives no result. A sample request walks the table one key
// per cycle from entry 0, finds the first pair of neighboring keys that
// brackets the query time, divides out a 17-bit fraction one bit per cycle
// and interpolates the three components through one shared multiplier. A
// sample gives entry 0 when the first key is held, the last key when the
// last key is held (the last key is set by key_count), and interpolates
// when it falls in pair S. The table scan and the serial divider set the
// length of a sample. One request is in work at a time; a finished result
// waits in the output register while the next request is taken.
// key_count (offset 0) may only be written while the block is idle.
module keyframe_vector_sampler #(
    parameter int KEY_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  kvs_pkg::t_in_req                i_in_req,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output kvs_pkg::t_out_req               o_out_req,
    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kvs_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [6:0]    r_key_count;
    logic          reg_wr;
    kvs_pkg::t_cmd cmd;
    kvs_pkg::t_sts sts;

    // Register write
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == kvs_pkg::REG_KEY_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= kvs_pkg::KEY_COUNT_RESET;
        end else if (reg_wr) begin
            r_key_count <= pwdata[6:0];
        end
    end

    // Register read
    assign prdata = (paddr[2] == kvs_pkg::REG_KEY_COUNT) ? {25'd0, r_key_count} : 32'd0;

    kvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_req.operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    kvs_datapath #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_key_count (r_key_count),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule
